[src/sem_pkg.sv]
// ---------------------------------------------------------------------------
// Sobel edge magnitude: shared package
// Types, register indexes and tap decoding shared by the controller,
// the datapath and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_WEIGHT_RED   = 3'd2;
   localparam logic [2:0] REG_WEIGHT_GREEN = 3'd3;
   localparam logic [2:0] REG_WEIGHT_BLUE  = 3'd4;

   // Field widths that the interface fixes.
   localparam int ROW_W  = 12;
   localparam int HGT_W  = 13;
   localparam int FW_W   = 12;
   localparam int CSR_W  = 13;
   localparam logic [HGT_W-1:0] HEIGHT_LIMIT = 13'd4096;

   // Offset of a window tap relative to the center, per axis.
   localparam logic [1:0] OFS_NEG = 2'd0;
   localparam logic [1:0] OFS_MID = 2'd1;
   localparam logic [1:0] OFS_POS = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic gray_load;
      logic div_step;
      logic pixel_write;
      logic drain_take;
      logic centre_load;
      logic tap_issue;
      logic square_load;
      logic sqrt_step;
      logic result_load;
      logic step_clear;
   } sem_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic drain_ok;
      logic emit_due;
      logic step_seven;
      logic step_eight;
      logic out_free;
   } sem_sts_type;

   // Row offset of tap 0..8 in raster order of the 3x3 window.
   function automatic logic [1:0] tap_row(input logic [3:0] tap);
      logic [1:0] r;
      case (tap)
         4'd0, 4'd1, 4'd2: r = OFS_NEG;
         4'd3, 4'd4, 4'd5: r = OFS_MID;
         default:          r = OFS_POS;
      endcase
      return r;
   endfunction

   // Column offset of tap 0..8.
   function automatic logic [1:0] tap_col(input logic [3:0] tap);
      logic [1:0] c;
      case (tap)
         4'd0, 4'd3, 4'd6: c = OFS_NEG;
         4'd1, 4'd4, 4'd7: c = OFS_MID;
         default:          c = OFS_POS;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[src/sem_ctrl.sv]
// ---------------------------------------------------------------------------
// Sobel edge magnitude: controller
// Sequences gray conversion, line store write, window read, square root and
// result hand-off for one accepted word at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module sem_ctrl
   import sem_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tuser,
   output logic        req_tready,
   output sem_cmd_type cmd,
   input  sem_sts_type sts
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIV    = 4'd1;
   localparam logic [3:0] ST_WRITE  = 4'd2;
   localparam logic [3:0] ST_CENTRE = 4'd3;
   localparam logic [3:0] ST_READ   = 4'd4;
   localparam logic [3:0] ST_LAST   = 4'd5;
   localparam logic [3:0] ST_SQUARE = 4'd6;
   localparam logic [3:0] ST_SQRT   = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0] state_ff, state_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser) begin
                  if (sts.drain_ok) begin
                     cmd.drain_take = 1'b1;
                     state_in       = ST_CENTRE;
                  end
               end else begin
                  cmd.gray_load  = 1'b1;
                  cmd.step_clear = 1'b1;
                  state_in       = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.step_seven) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.pixel_write = 1'b1;
            state_in = sts.emit_due ? ST_CENTRE : ST_IDLE;
         end
         ST_CENTRE: begin
            cmd.centre_load = 1'b1;
            cmd.step_clear  = 1'b1;
            state_in        = ST_READ;
         end
         ST_READ: begin
            cmd.tap_issue = 1'b1;
            if (sts.step_eight) state_in = ST_LAST;
         end
         ST_LAST: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square_load = 1'b1;
            cmd.step_clear  = 1'b1;
            state_in        = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.step_seven) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/sem_datapath.sv]
// ---------------------------------------------------------------------------
// Sobel edge magnitude: datapath
// Configuration registers, gray divider, line store ring, window taps,
// gradient accumulators, square root and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sem_datapath
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)
(
   input  wire               clock,
   input  wire               reset,
   input  wire  [23:0]       req_tdata,
   input  wire               csr_we,
   input  wire  [2:0]        csr_index,
   input  wire  [CSR_W-1:0]  csr_wdata,
   input  sem_cmd_type       cmd,
   output sem_sts_type       sts,
   input  wire               rsp_tready,
   output logic              rsp_tvalid,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast
);

   localparam int RING = 4 * MAX_WIDTH;
   localparam int AW   = $clog2(RING);
   localparam int CW   = $clog2(MAX_WIDTH + 1);

   // Configuration registers.
   logic [FW_W-1:0]  width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [7:0]       wred_ff, wgreen_ff, wblue_ff;

   // Stream position and ring bookkeeping.
   logic [CW-1:0]    icol_ff, ocol_ff;
   logic [ROW_W-1:0] irow_ff, orow_ff;
   logic [AW-1:0]    wp_ff, pending_ff, back_ff, centre_ff;

   // Arithmetic state.
   logic [17:0]        rem_ff;
   logic [9:0]         wsum_ff;
   logic [7:0]         quo_ff;
   logic [3:0]         step_ff;
   logic [7:0]         rd_data_ff;
   logic               rd_ok_ff, rd_en_ff;
   logic [3:0]         rd_tap_ff;
   logic signed [11:0] gx_ff, gy_ff;
   logic [21:0]        sq_ff;
   logic [7:0]         root_ff;
   logic               out_valid_ff;
   logic [7:0]         out_data_ff;
   logic               out_last_ff;

   logic [7:0] ring_mem [RING];

   // Effective frame size after clamping.
   logic [CW-1:0]    eff_w;
   logic [HGT_W-1:0] eff_h;
   always_comb begin
      if (width_ff == '0) eff_w = CW'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
      else eff_w = CW'(width_ff);
      if (height_ff == '0) eff_h = HGT_W'(1);
      else if (height_ff > HEIGHT_LIMIT) eff_h = HEIGHT_LIMIT;
      else eff_h = height_ff;
   end

   // Status for the controller.
   assign sts.drain_ok   = (pending_ff != '0) && (icol_ff == '0) && (irow_ff == '0);
   assign sts.emit_due   = {1'b0, pending_ff} >= ((AW+1)'(eff_w) + (AW+1)'(1));
   assign sts.step_seven = (step_ff == 4'd7);
   assign sts.step_eight = (step_ff == 4'd8);
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   // Divider and square root trial values for the current bit.
   logic [2:0]  bit_sel;
   logic [17:0] div_trial;
   logic [7:0]  root_trial;
   logic [15:0] root_sq;
   assign bit_sel    = ~step_ff[2:0];
   assign div_trial  = 18'(wsum_ff) << bit_sel;
   assign root_trial = root_ff | (8'd1 << bit_sel);
   assign root_sq    = root_trial * root_trial;

   // Wrap helpers for positions.
   logic             icol_wrap, irow_wrap, ocol_wrap, orow_wrap;
   assign icol_wrap = ({1'b0, icol_ff} + (CW+1)'(1)) >= {1'b0, eff_w};
   assign irow_wrap = ({1'b0, irow_ff} + HGT_W'(1)) >= eff_h;
   assign ocol_wrap = ({1'b0, ocol_ff} + (CW+1)'(1)) >= {1'b0, eff_w};
   assign orow_wrap = ({1'b0, orow_ff} + HGT_W'(1)) >= eff_h;

   // Center address: write pointer minus the pending distance, modulo the ring.
   logic [AW:0] centre_sum;
   logic [AW-1:0] centre_val;
   always_comb begin
      centre_sum = {1'b0, wp_ff} + (AW+1)'(RING) - {1'b0, back_ff};
      if (centre_sum >= (AW+1)'(RING)) centre_val = AW'(centre_sum - (AW+1)'(RING));
      else centre_val = AW'(centre_sum);
   end

   // Tap address and in-frame test for the current window position.
   logic [1:0]    tr, tc;
   logic          tap_ok;
   logic [AW+1:0] pos_ofs, neg_ofs, addr_sum, addr_one;
   logic [AW-1:0] tap_addr;
   always_comb begin
      tr = tap_row(step_ff);
      tc = tap_col(step_ff);
      tap_ok = 1'b1;
      pos_ofs = '0;
      neg_ofs = '0;
      if (tr == OFS_NEG) begin
         tap_ok  = (orow_ff != '0);
         neg_ofs = (AW+2)'(eff_w);
      end else if (tr == OFS_POS) begin
         if (orow_wrap) tap_ok = 1'b0;
         pos_ofs = (AW+2)'(eff_w);
      end
      if (tc == OFS_NEG) begin
         if (ocol_ff == '0) tap_ok = 1'b0;
         neg_ofs = neg_ofs + (AW+2)'(1);
      end else if (tc == OFS_POS) begin
         if (ocol_wrap) tap_ok = 1'b0;
         pos_ofs = pos_ofs + (AW+2)'(1);
      end
      addr_sum = (AW+2)'(centre_ff) + pos_ofs + (AW+2)'(RING) - neg_ofs;
      if (addr_sum >= (AW+2)'(2 * RING)) addr_one = addr_sum - (AW+2)'(2 * RING);
      else addr_one = addr_sum;
      if (addr_one >= (AW+2)'(RING)) tap_addr = AW'(addr_one - (AW+2)'(RING));
      else tap_addr = AW'(addr_one);
   end

   // Weighted tap contribution to both gradients.
   logic [1:0]          ar, ac;
   logic signed [11:0]  pix1, pix2, gx_add, gy_add;
   always_comb begin
      ar = tap_row(rd_tap_ff);
      ac = tap_col(rd_tap_ff);
      pix1 = rd_ok_ff ? 12'(rd_data_ff) : 12'sd0;
      pix2 = pix1 <<< 1;
      gx_add = 12'sd0;
      gy_add = 12'sd0;
      if (ac == OFS_NEG) gx_add = (ar == OFS_MID) ? pix2 : pix1;
      else if (ac == OFS_POS) gx_add = (ar == OFS_MID) ? -pix2 : -pix1;
      if (ar == OFS_NEG) gy_add = (ac == OFS_MID) ? pix2 : pix1;
      else if (ar == OFS_POS) gy_add = (ac == OFS_MID) ? -pix2 : -pix1;
   end

   // Line store ring.
   always_ff @(posedge clock) begin
      if (cmd.pixel_write) begin
         ring_mem[wp_ff] <= quo_ff;
      end
      rd_data_ff <= ring_mem[tap_addr];
   end

   // Control registers: configuration, positions, counters, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= FW_W'(640);
         height_ff    <= HGT_W'(480);
         wred_ff      <= 8'd1;
         wgreen_ff    <= 8'd1;
         wblue_ff     <= 8'd1;
         icol_ff      <= '0;
         irow_ff      <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         wp_ff        <= '0;
         pending_ff   <= '0;
         step_ff      <= '0;
         rd_en_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.step_clear) step_ff <= '0;
         else if (cmd.div_step || cmd.tap_issue || cmd.sqrt_step) step_ff <= step_ff + 4'd1;
         rd_en_ff <= cmd.tap_issue;

         if (cmd.pixel_write) begin
            wp_ff <= (wp_ff == AW'(RING - 1)) ? '0 : wp_ff + AW'(1);
            if (!sts.emit_due) pending_ff <= pending_ff + AW'(1);
            if (icol_wrap) begin
               icol_ff <= '0;
               irow_ff <= irow_wrap ? '0 : irow_ff + ROW_W'(1);
            end else begin
               icol_ff <= icol_ff + CW'(1);
            end
         end
         if (cmd.drain_take) pending_ff <= pending_ff - AW'(1);

         if (cmd.result_load) begin
            out_valid_ff <= 1'b1;
            if (ocol_wrap) begin
               ocol_ff <= '0;
               orow_ff <= orow_wrap ? '0 : orow_ff + ROW_W'(1);
            end else begin
               ocol_ff <= ocol_ff + CW'(1);
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end

         // Configuration writes; a size change restarts the stream.
         if (csr_we) begin
            case (csr_index)
               REG_FRAME_WIDTH:  width_ff  <= csr_wdata[FW_W-1:0];
               REG_FRAME_HEIGHT: height_ff <= csr_wdata;
               REG_WEIGHT_RED:   wred_ff   <= csr_wdata[7:0];
               REG_WEIGHT_GREEN: wgreen_ff <= csr_wdata[7:0];
               REG_WEIGHT_BLUE:  wblue_ff  <= csr_wdata[7:0];
               default: ;
            endcase
            if (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT) begin
               icol_ff    <= '0;
               irow_ff    <= '0;
               ocol_ff    <= '0;
               orow_ff    <= '0;
               pending_ff <= '0;
            end
         end
      end
   end

   // Payload registers of the arithmetic path.
   always_ff @(posedge clock) begin
      if (cmd.gray_load) begin
         rem_ff  <= 18'(wred_ff) * 18'(req_tdata[7:0])
                  + 18'(wgreen_ff) * 18'(req_tdata[15:8])
                  + 18'(wblue_ff) * 18'(req_tdata[23:16]);
         wsum_ff <= 10'(wred_ff) + 10'(wgreen_ff) + 10'(wblue_ff);
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         if (wsum_ff != '0 && rem_ff >= div_trial) begin
            rem_ff          <= rem_ff - div_trial;
            quo_ff[bit_sel] <= 1'b1;
         end
      end

      if (cmd.pixel_write) back_ff <= pending_ff + AW'(1);
      else if (cmd.drain_take) back_ff <= pending_ff;

      if (cmd.tap_issue) begin
         rd_ok_ff  <= tap_ok;
         rd_tap_ff <= step_ff;
      end

      if (cmd.centre_load) begin
         centre_ff <= centre_val;
         gx_ff     <= '0;
         gy_ff     <= '0;
      end else if (rd_en_ff) begin
         gx_ff <= gx_ff + gx_add;
         gy_ff <= gy_ff + gy_add;
      end

      if (cmd.square_load) begin
         sq_ff   <= 22'(22'(gx_ff) * 22'(gx_ff)) + 22'(22'(gy_ff) * 22'(gy_ff));
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (root_sq <= sq_ff[15:0]) root_ff <= root_trial;
      end

      if (cmd.result_load) begin
         out_data_ff <= (sq_ff[21:16] != '0) ? 8'd255 : root_ff;
         out_last_ff <= orow_wrap && ocol_wrap;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

[src/sobel_edge_magnitude.sv]
// ---------------------------------------------------------------------------
// Sobel edge magnitude: top level
// Gray conversion, 3x3 Sobel gradient and saturated magnitude over a raster
// stream of RGB pixels.
// ---------------------------------------------------------------------------
// Usage:
// - req_ carries one word per pixel (tuser low) or a drain word (tuser high).
//   Pixels arrive in raster order; results leave on rsp_ in raster order,
//   frame_width+1 pixels behind the input. After a complete frame, drain
//   words release the pending results one per word; tlast marks the
//   frame's final pixel.
// - csr_ writes frame size and gray weights; a size write restarts the stream.
// - Throughput: one word at a time. A pixel that releases no result takes
//   one load, 8 divider steps for the gray quotient and one line store
//   write. A result adds center setup, 9 single-port reads of the line
//   store, a drain state, a squaring step, 8 square root steps and the
//   output load. A drain word runs the result steps alone.
// - The next word is taken while a result waits in the output register; a
//   stalled receiver holds the block only when a new result is ready.
// - Reset restores the register defaults and clears positions; the line
//   store needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
)
(
   input  wire               clock,
   input  wire               reset,
   // req_tdata: red_value [7:0], green_value [15:8], blue_value [23:16]
   input  wire  [23:0]       req_tdata,
   // req_tuser: command (0 pixel, 1 drain)
   input  wire               req_tuser,
   input  wire               req_tvalid,
   output logic              req_tready,
   // rsp_tdata: edge_value [7:0]
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire               rsp_tready,
   input  wire               csr_we,
   input  wire  [2:0]        csr_index,
   input  wire  [CSR_W-1:0]  csr_wdata
);

   sem_cmd_type cmd;
   sem_sts_type sts;

   sem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   sem_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[tb/tb_sobel_edge_magnitude.sv]
// ---------------------------------------------------------------------------
// Sobel edge magnitude: testbench
// Streams RGB pixel and drain words into the block over several frame sizes
// and gray weights, predicts every edge result with its own line store model
// and compares each result word against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude;
   import sem_pkg::*;

   localparam int RING       = 8192;
   localparam int WIDTH_MAX  = 2048;
   localparam int SETTLE     = 64;
   localparam int CYCLE_CAP  = 3000000;
   localparam int ITEM_GOAL  = 1550;
   localparam bit CMD_PIXEL  = 1'b0;
   localparam bit CMD_DRAIN  = 1'b1;

   typedef struct {
      bit         cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         hold_for_empty;
   } pixel_word_type;

   typedef struct {
      logic [7:0] edge_val;
      logic       frame_end;
   } edge_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic [23:0]       req_tdata = '0;
   logic              req_tuser = 1'b0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   sobel_edge_magnitude i_dut (
      .clock, .reset, .req_tdata, .req_tuser, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tlast, .rsp_tvalid, .rsp_tready,
      .csr_we, .csr_index, .csr_wdata
   );

   pixel_word_type pending_words[$];
   edge_word_type  expected_edges[$];
   int          words_queued = 0;
   int          words_taken = 0;
   int          mismatches = 0;
   int          cycles = 0;
   int          idle_mode = 0;
   bit          long_hold_req = 1'b0;
   bit          long_hold_done = 1'b0;
   int          long_hold_left = 0;
   logic        req_took = 1'b0;

   // Predictor state: registers, gray line ring and stream positions.
   logic [11:0] width_reg;
   logic [12:0] height_reg;
   logic [7:0]  wt_red, wt_green, wt_blue;
   logic [7:0]  gray_ring[RING];
   int          in_col, in_row, out_col, out_row, ring_wr, backlog;

   // Clock generator.
   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > WIDTH_MAX) return WIDTH_MAX;
      return width_reg;
   endfunction

   function automatic int active_height();
      if (height_reg == 0) return 1;
      if (height_reg > 4096) return 4096;
      return height_reg;
   endfunction

   function automatic void restart_stream();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; backlog = 0;
   endfunction

   function automatic void apply_register(logic [2:0] idx, int val);
      case (idx)
         REG_FRAME_WIDTH: begin
            width_reg = val[11:0];
            restart_stream();
         end
         REG_FRAME_HEIGHT: begin
            height_reg = val[12:0];
            restart_stream();
         end
         REG_WEIGHT_RED:   wt_red = val[7:0];
         REG_WEIGHT_GREEN: wt_green = val[7:0];
         REG_WEIGHT_BLUE:  wt_blue = val[7:0];
         default: ;
      endcase
   endfunction

   // Gradient magnitude of the next output position, centered "back" pixels
   // behind the ring write position.
   function automatic void predict_edge(int back);
      int w, h, centre, gx, gy, r, c, idx, sq, mag;
      logic [7:0] pix;
      edge_word_type e;
      w = active_width();
      h = active_height();
      centre = (ring_wr + RING - back) % RING;
      gx = 0;
      gy = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            r = out_row + dr;
            c = out_col + dc;
            pix = 8'd0;
            if (r >= 0 && r < h && c >= 0 && c < w) begin
               idx = (centre + dr * w + dc + RING) % RING;
               pix = gray_ring[idx];
            end
            gx += (dc == 0) ? 0 : -dc * ((dr == 0) ? 2 : 1) * int'(pix);
            gy += (dr == 0) ? 0 : -dr * ((dc == 0) ? 2 : 1) * int'(pix);
         end
      end
      sq = gx * gx + gy * gy;
      mag = 0;
      while (mag < 255 && (mag + 1) * (mag + 1) <= sq) mag++;
      e.edge_val = mag[7:0];
      e.frame_end = (out_row == h - 1 && out_col == w - 1);
      expected_edges.push_back(e);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
   endfunction

   function automatic void predict_word(bit cmd, logic [23:0] data);
      int w, h, sum, gray;
      w = active_width();
      h = active_height();
      if (cmd == CMD_DRAIN) begin
         // A drain only releases results between frames.
         if (backlog != 0 && in_col == 0 && in_row == 0) begin
            predict_edge(backlog);
            backlog--;
         end
         return;
      end
      sum = wt_red + wt_green + wt_blue;
      gray = 0;
      if (sum != 0)
         gray = (wt_red * data[7:0] + wt_green * data[15:8] + wt_blue * data[23:16]) / sum;
      gray_ring[ring_wr] = gray[7:0];
      ring_wr = (ring_wr + 1) % RING;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
         if (in_row >= h) in_row = 0;
      end
      backlog++;
      if (backlog > w + 1) begin
         predict_edge(backlog);
         backlog--;
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR at cycle %0d: %s is %0d, expected %0d", cycles, what, got, want);
      mismatches++;
   endtask

   // Input driver: presents the next queued word unless idling or holding it until no results are outstanding.
   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (idle_mode == 0) ? 20 : (idle_mode == 1) ? 69 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct &&
             !(pending_words[0].hold_for_empty && expected_edges.size() != 0)) begin
            pixel_word_type pw;
            pw = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= pw.cmd;
            req_tdata <= {pw.blue, pw.green, pw.red};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus one long hold-off.
   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (idle_mode == 0) ? 69 : (idle_mode == 1) ? 20 : 0;
      if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         long_hold_left <= 500;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Monitor: checks result words and predicts from accepted input words.
   always @(posedge clock) begin
      edge_word_type e;
      req_took <= req_tvalid && req_tready && !reset;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_edges.size() == 0) begin
            report_mismatch("unexpected result word, edge", rsp_tdata, -1);
         end else begin
            e = expected_edges.pop_front();
            if (rsp_tdata !== e.edge_val) report_mismatch("edge_value", rsp_tdata, e.edge_val);
            if (rsp_tlast !== e.frame_end) report_mismatch("tlast", rsp_tlast, e.frame_end);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         predict_word(req_tuser, req_tdata);
         words_taken++;
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_word(bit cmd, int r, int g, int b, bit hold = 1'b0);
      pixel_word_type pw;
      pw.cmd = cmd;
      pw.red = r[7:0];
      pw.green = g[7:0];
      pw.blue = b[7:0];
      pw.hold_for_empty = hold;
      pending_words.push_back(pw);
      words_queued++;
   endtask

   task automatic queue_random_pixel();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) queue_word(CMD_PIXEL, 255, 255, 255);
      else if (sel == 1) queue_word(CMD_PIXEL, 0, 0, 0);
      else queue_word(CMD_PIXEL, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(99) < 3);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (words_taken != words_queued || expected_edges.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      apply_register(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_weight();
      int s;
      s = $urandom_range(5);
      return (s == 0) ? 0 : (s == 1) ? 255 : $urandom_range(255);
   endfunction

   // Stimulus: directed frames first, then random phases.
   initial begin
      int w, h, frames, sel;
      width_reg = 12'd640;
      height_reg = 13'd480;
      wt_red = 8'd1;
      wt_green = 8'd1;
      wt_blue = 8'd1;
      ring_wr = 0;
      restart_stream();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: 3x3 frame with extreme pixels, drains before, inside and after the frame.
      write_register(REG_FRAME_WIDTH, 3);
      write_register(REG_FRAME_HEIGHT, 3);
      queue_word(CMD_DRAIN, 1, 2, 3);
      for (int i = 0; i < 9; i++) begin
         if (i % 2 == 0) queue_word(CMD_PIXEL, 255, 255, 255);
         else queue_word(CMD_PIXEL, 0, 0, 0);
         if (i == 4) queue_word(CMD_DRAIN, 255, 255, 255);
      end
      for (int i = 0; i < 5; i++) queue_word(CMD_DRAIN, 0, 0, 0);
      wait_idle();

      // Directed: zero weights, then maximum weights with single and paired channels.
      write_register(REG_WEIGHT_RED, 0);
      write_register(REG_WEIGHT_GREEN, 0);
      write_register(REG_WEIGHT_BLUE, 0);
      write_register(REG_FRAME_WIDTH, 0);
      write_register(REG_FRAME_HEIGHT, 0);
      queue_word(CMD_PIXEL, 255, 255, 255);
      queue_word(CMD_DRAIN, 0, 0, 0);
      wait_idle();
      write_register(REG_WEIGHT_RED, 255);
      write_register(REG_WEIGHT_GREEN, 255);
      write_register(REG_WEIGHT_BLUE, 255);
      write_register(REG_FRAME_WIDTH, 2);
      write_register(REG_FRAME_HEIGHT, 2);
      queue_word(CMD_PIXEL, 255, 0, 0);
      queue_word(CMD_PIXEL, 0, 255, 0);
      queue_word(CMD_PIXEL, 0, 0, 255);
      queue_word(CMD_PIXEL, 255, 255, 0);
      for (int i = 0; i < 4; i++) queue_word(CMD_DRAIN, 0, 0, 0);
      wait_idle();

      // Random phases until enough words have gone in.
      while (words_queued < ITEM_GOAL) begin
         idle_mode = (words_queued < ITEM_GOAL / 3) ? 0 :
                     (words_queued < 2 * ITEM_GOAL / 3) ? 1 : 2;
         sel = $urandom_range(19);
         write_register(REG_WEIGHT_RED, pick_weight());
         write_register(REG_WEIGHT_GREEN, pick_weight());
         write_register(REG_WEIGHT_BLUE, pick_weight());
         if (sel == 0) begin
            // Oversized frame: width and height saturate, only a partial row.
            write_register(REG_FRAME_WIDTH, $urandom_range(1) ? 4095 : 2048);
            write_register(REG_FRAME_HEIGHT, $urandom_range(1) ? 8191 : 4096);
            for (int i = 0; i < 12; i++) queue_random_pixel();
            queue_word(CMD_DRAIN, 0, 0, 0);
         end else if (sel == 1) begin
            // Single column with a height above the limit; 20 pixels go in.
            write_register(REG_FRAME_WIDTH, 1);
            write_register(REG_FRAME_HEIGHT, 8191);
            for (int i = 0; i < 20; i++) queue_random_pixel();
         end else begin
            if (!long_hold_req && words_queued > ITEM_GOAL / 2) begin
               long_hold_req = 1'b1;
               w = 8;
               h = 6;
            end else begin
               w = $urandom_range(8);
               h = $urandom_range(6);
            end
            write_register(REG_FRAME_WIDTH, w);
            write_register(REG_FRAME_HEIGHT, h);
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
               for (int i = 0; i < w * h; i++) begin
                  queue_random_pixel();
                  if ($urandom_range(99) < 3) queue_word(CMD_DRAIN, 0, 0, 0);
               end
            end
            // Flush the backlog, sometimes with surplus drains.
            for (int i = 0; i < w + 1 + $urandom_range(2); i++)
               queue_word(CMD_DRAIN, $urandom_range(255), 0, 0);
            // Sometimes leave the stream mid-frame before the next size write.
            if ($urandom_range(3) == 0) begin
               for (int i = 0; i < $urandom_range(1, w); i++) queue_random_pixel();
            end
         end
         wait_idle();
      end

      idle_mode = 2;
      wait_idle();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[sim.f]
src/sem_pkg.sv
src/sem_ctrl.sv
src/sem_datapath.sv
src/sobel_edge_magnitude.sv
tb/tb_sobel_edge_magnitude.sv
